// File: sv/dxw_pkg.sv
// Shared types and constants for the distance-weighted exponential sum block.
package dxw_pkg;

   localparam int APPROX_STEPS_DEFAULT = 24;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [32:0] LN2_Q28 = 33'd186065279;
   localparam logic [32:0] LN2_X24 = 33'd4465566696;
   localparam logic [30:0] EXP_MAX = 31'h7FFFFFFF;

   typedef enum logic [2:0] {
      CSR_DECAY_RATE = 3'd0,
      CSR_WEIGHT_MAX = 3'd1,
      CSR_WEIGHT_MIN = 3'd2,
      CSR_REF_X      = 3'd3,
      CSR_REF_Y      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic signed [47:0] total;
      logic               overflowed;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] decay_rate;
      logic signed [31:0] weight_max;
      logic signed [31:0] weight_min;
      logic signed [31:0] ref_x;
      logic signed [31:0] ref_y;
   } cfg_type;

   typedef struct packed {
      logic [30:0] ax;
      logic [30:0] ay;
      logic        scaled;
      logic        last;
   } qent_type;

endpackage

// File: sv/dxw_front.sv
// Front end: accepts requests and reduces them to scaled distance magnitudes.
module dxw_front (
   input  logic             req_valid,
   output logic             req_stall,
   input  dxw_pkg::req_type req_data,
   input  dxw_pkg::cfg_type cfg,
   input  logic             q_full,
   output logic             q_push,
   output dxw_pkg::qent_type q_data
);

   logic signed [32:0] dx;
   logic signed [32:0] dy;
   logic [32:0]        mx;
   logic [32:0]        my;
   logic               big;

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

   always_comb begin
      dx  = 33'(req_data.coord_x) - 33'(cfg.ref_x);
      dy  = 33'(req_data.coord_y) - 33'(cfg.ref_y);
      mx  = dx[32] ? 33'(-dx) : 33'(dx);
      my  = dy[32] ? 33'(-dy) : 33'(dy);
      big = mx[32] | mx[31] | my[32] | my[31];
      q_data.ax     = big ? mx[31:1] : mx[30:0];
      q_data.ay     = big ? my[31:1] : my[30:0];
      q_data.scaled = big;
      q_data.last   = req_data.last_item;
   end

endmodule

// File: sv/dxw_queue.sv
// Small first-in first-out queue between the front end and the back end.
module dxw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dxw_pkg::qent_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output dxw_pkg::qent_type head
);

   localparam int Depth = dxw_pkg::QUEUE_DEPTH;
   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

   dxw_pkg::qent_type    mem_ff [Depth];
   logic [PtrW-1:0]      wr_ff, wr_in;
   logic [PtrW-1:0]      rd_ff, rd_in;
   logic [PtrW:0]        cnt_ff, cnt_in;

   assign full      = (cnt_ff == (PtrW+1)'(Depth));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push & ~pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop & ~push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: sv/dxw_back.sv
// Back end: square root, exponential series, weighting and saturating sum.
module dxw_back #(
   parameter int APPROX_STEPS = dxw_pkg::APPROX_STEPS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  dxw_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  dxw_pkg::qent_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dxw_pkg::rsp_type  rsp_data
);

   localparam int KW = $clog2(APPROX_STEPS + 1);
   localparam logic signed [50:0] SumMax = 51'sd140737488355327;
   localparam logic signed [50:0] SumMin = -51'sd140737488355328;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_ROOT, ST_T_HI, ST_T_LO, ST_CLASS, ST_REDUCE,
      ST_MUL_R, ST_MUL_INV, ST_FIX, ST_SHIFT, ST_SCALE, ST_WEIGHT, ST_ACC
   } state_type;

   logic [32:0] recip_tab [1:APPROX_STEPS];

   for (genvar gk = 1; gk <= APPROX_STEPS; gk++) begin : g_recip
      localparam logic [32:0] RecipVal = 33'((64'd4294967296 + gk - 1) / gk);
      assign recip_tab[gk] = RecipVal;
   end

   state_type          state_ff;
   dxw_pkg::qent_type  ent_ff;
   logic [62:0]        sq_ff;
   logic [63:0]        rem_ff;
   logic [63:0]        res_ff;
   logic [63:0]        bit_ff;
   logic [4:0]         iter_ff;
   logic [49:0]        tm_ff;
   logic [32:0]        tp_ff;
   logic [5:0]         np_ff;
   logic [2:0]         bidx_ff;
   logic [28:0]        term_ff;
   logic [30:0]        acc_ff;
   logic [27:0]        p_ff;
   logic [27:0]        qe_ff;
   logic [KW-1:0]      k_ff;
   logic [30:0]        e_ff;
   logic [63:0]        m_ff;
   logic               dneg_ff;
   logic signed [49:0] w_ff;
   logic signed [47:0] sum_ff;
   logic               ovf_ff;
   logic               rsp_valid_ff;
   dxw_pkg::rsp_type   rsp_ff;

   logic [31:0]        rm;
   logic               rneg;
   logic [32:0]        dval;
   logic [63:0]        trial;
   logic [33:0]        cand;
   logic [56:0]        tr_prod;
   logic [60:0]        inv_prod;
   logic [27+KW:0]     chk;
   logic [27:0]        qfix;
   logic [33:0]        eshift;
   logic [5:0]         shl;
   logic [5:0]         shr;
   logic signed [32:0] diff;
   logic [32:0]        dmag;
   logic signed [48:0] scaled;
   logic signed [50:0] snext;
   logic               ssat;
   logic signed [47:0] sclip;

   function automatic logic [33:0] LN2_SHIFTED(input logic [2:0] b);
      LN2_SHIFTED = 34'(dxw_pkg::LN2_Q28) << b;
   endfunction

   assign q_pop     = (state_ff == ST_IDLE) & q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rneg     = cfg.decay_rate[31];
      rm       = rneg ? 32'(-cfg.decay_rate) : 32'(cfg.decay_rate);
      dval     = ent_ff.scaled ? {res_ff[31:0], 1'b0} : {1'b0, res_ff[31:0]};
      trial    = res_ff + bit_ff;
      cand     = 34'(LN2_SHIFTED(bidx_ff));
      tr_prod  = 57'(term_ff) * 57'(tp_ff[27:0]);
      inv_prod = 61'(p_ff) * 61'(recip_tab[k_ff]);
      chk      = (28+KW)'(qe_ff) * (28+KW)'(k_ff);
      qfix     = (chk > (28+KW)'(p_ff)) ? qe_ff - 1'b1 : qe_ff;
      shl      = np_ff - 6'd36;
      shr      = 6'd36 - np_ff;
      if (np_ff >= 6'd36) begin
         eshift = 34'(acc_ff) << shl[1:0];
      end else begin
         eshift = 34'(acc_ff) >> shr;
      end
      diff   = 33'(cfg.weight_max) - 33'(cfg.weight_min);
      dmag   = diff[32] ? 33'(-diff) : 33'(diff);
      scaled = dneg_ff ? -49'(49'((m_ff + 64'd65535) >> 16))
                       : 49'(m_ff >> 16);
      snext  = 51'(sum_ff) + 51'(w_ff);
      ssat   = (snext > SumMax) | (snext < SumMin);
      if (snext > SumMax) begin
         sclip = SumMax[47:0];
      end else if (snext < SumMin) begin
         sclip = SumMin[47:0];
      end else begin
         sclip = snext[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff & ~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  ent_ff   <= q_data;
                  state_ff <= ST_SQ_X;
               end
            end
            ST_SQ_X: begin
               sq_ff    <= 63'(62'(ent_ff.ax) * 62'(ent_ff.ax));
               state_ff <= ST_SQ_Y;
            end
            ST_SQ_Y: begin
               rem_ff   <= 64'(sq_ff) + 64'(62'(ent_ff.ay) * 62'(ent_ff.ay));
               res_ff   <= '0;
               bit_ff   <= 64'd1 << 62;
               iter_ff  <= '0;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (rem_ff >= trial) begin
                  rem_ff <= rem_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff  <= bit_ff >> 2;
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == 5'd31) begin
                  state_ff <= ST_T_HI;
               end
            end
            ST_T_HI: begin
               tm_ff    <= 50'(49'(rm) * 49'(dval[32:16]));
               state_ff <= ST_T_LO;
            end
            ST_T_LO: begin
               tm_ff    <= tm_ff + 50'((48'(rm) * 48'(dval[15:0])) >> 16);
               state_ff <= ST_CLASS;
            end
            ST_CLASS: begin
               np_ff   <= '0;
               bidx_ff <= 3'd5;
               if (!rneg && tm_ff >= (50'd11 << 28)) begin
                  e_ff     <= dxw_pkg::EXP_MAX;
                  ovf_ff   <= 1'b1;
                  state_ff <= ST_SCALE;
               end else if (rneg && tm_ff >= (50'd16 << 28)) begin
                  e_ff     <= '0;
                  state_ff <= ST_SCALE;
               end else begin
                  tp_ff    <= rneg ? dxw_pkg::LN2_X24 - tm_ff[32:0]
                                   : dxw_pkg::LN2_X24 + tm_ff[32:0];
                  state_ff <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               if (34'(tp_ff) >= cand) begin
                  tp_ff         <= 33'(34'(tp_ff) - cand);
                  np_ff[bidx_ff] <= 1'b1;
               end
               bidx_ff <= bidx_ff - 1'b1;
               if (bidx_ff == 3'd0) begin
                  term_ff  <= 29'd1 << 28;
                  acc_ff   <= 31'd1 << 28;
                  k_ff     <= KW'(1);
                  state_ff <= ST_MUL_R;
               end
            end
            ST_MUL_R: begin
               p_ff     <= 28'(tr_prod >> 28);
               state_ff <= ST_MUL_INV;
            end
            ST_MUL_INV: begin
               qe_ff    <= 28'(inv_prod >> 32);
               state_ff <= ST_FIX;
            end
            ST_FIX: begin
               term_ff <= 29'(qfix);
               acc_ff  <= acc_ff + 31'(qfix);
               if (k_ff == KW'(APPROX_STEPS)) begin
                  state_ff <= ST_SHIFT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= ST_MUL_R;
               end
            end
            ST_SHIFT: begin
               if (eshift > 34'(dxw_pkg::EXP_MAX)) begin
                  e_ff   <= dxw_pkg::EXP_MAX;
                  ovf_ff <= 1'b1;
               end else begin
                  e_ff <= eshift[30:0];
               end
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               m_ff     <= 64'(dmag) * 64'(e_ff);
               dneg_ff  <= diff[32];
               state_ff <= ST_WEIGHT;
            end
            ST_WEIGHT: begin
               w_ff     <= 50'(scaled) + 50'(cfg.weight_min);
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (!ent_ff.last) begin
                  sum_ff   <= sclip;
                  ovf_ff   <= ovf_ff | ssat;
                  state_ff <= ST_IDLE;
               end else if (!rsp_valid_ff) begin
                  rsp_ff.total      <= sclip;
                  rsp_ff.overflowed <= ovf_ff | ssat;
                  rsp_valid_ff      <= 1'b1;
                  sum_ff            <= '0;
                  ovf_ff            <= 1'b0;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> (k_ff >= KW'(1) && k_ff <= KW'(APPROX_STEPS)))
      else $error("series index out of range");

   a_rsp_from_acc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_ACC && $past(ent_ff.last)))
      else $error("response raised outside the last accumulate step");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_SQ_X))
      else $error("queue pop did not start a computation");

   a_clear_after_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (sum_ff == '0 && !ovf_ff))
      else $error("accumulator not cleared after response");

endmodule

// File: sv/exp_distance_weight_sum.sv
// Top level: configuration registers, front end, queue and back end.
// The back end sequencer works on one item at a time and pops the next from the queue
// only when it is back in idle: 32 square root steps, six reduction steps, then a
// multiply, reciprocal multiply and fix step for each series term.
// Reset is synchronous: it clears the sum, overflow flag, queue and state and
// loads the configuration defaults.
module exp_distance_weight_sum #(
   parameter int APPROX_STEPS = dxw_pkg::APPROX_STEPS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dxw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dxw_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   dxw_pkg::cfg_type  cfg_ff;
   logic              q_full;
   logic              q_push;
   logic              q_pop;
   logic              q_valid;
   dxw_pkg::qent_type q_in;
   dxw_pkg::qent_type q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_rate <= '0;
         cfg_ff.weight_max <= 32'sd65536;
         cfg_ff.weight_min <= '0;
         cfg_ff.ref_x      <= '0;
         cfg_ff.ref_y      <= '0;
      end else if (csr_valid & csr_ready) begin
         unique case (csr_index)
            dxw_pkg::CSR_DECAY_RATE: cfg_ff.decay_rate <= csr_wdata;
            dxw_pkg::CSR_WEIGHT_MAX: cfg_ff.weight_max <= csr_wdata;
            dxw_pkg::CSR_WEIGHT_MIN: cfg_ff.weight_min <= csr_wdata;
            dxw_pkg::CSR_REF_X:      cfg_ff.ref_x      <= csr_wdata;
            dxw_pkg::CSR_REF_Y:      cfg_ff.ref_y      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dxw_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   dxw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   dxw_back #(
      .APPROX_STEPS (APPROX_STEPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/sv/tb_exp_distance_weight_sum.sv
// Testbench for the distance-weighted exponential sum block: random and directed tests.
`timescale 1ns / 100ps

module tb_exp_distance_weight_sum;

   localparam int STEPS = 24;
   localparam longint LN2 = 186065279;
   localparam longint TOTAL_MAX = 64'sd140737488355327;
   localparam longint TOTAL_MIN = -64'sd140737488355328;
   localparam longint CYCLE_LIMIT = 6000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   dxw_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   dxw_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   longint mdl_rate, mdl_wmax, mdl_wmin, mdl_rx, mdl_ry;
   longint mdl_sum;
   bit mdl_ovf;
   dxw_pkg::rsp_type expected_totals[$];
   int error_count = 0;
   int requests_sent = 0;
   int totals_seen = 0;
   longint cycle_count = 0;

   exp_distance_weight_sum #(.APPROX_STEPS(STEPS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned rem, res, bitv;
      rem = v;
      res = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned exp_fixed(longint t);
      longint tp, np, n;
      longint unsigned r, acc, term;
      tp = t + 24 * LN2;
      np = tp / LN2;
      r = tp - np * LN2;
      n = np - 24;
      acc = 64'd1 << 28;
      term = acc;
      for (int k = 1; k <= STEPS; k++) begin
         term = ((term * r) >> 28) / k;
         acc += term;
      end
      if (n >= 12) return acc << (n - 12);
      return acc >> (12 - n);
   endfunction

   function automatic longint weight_of(longint cx, longint cy);
      longint unsigned ax, ay, d, rm, tm, e, m;
      longint diff, scaled;
      int sh;
      ax = mag(cx - mdl_rx);
      ay = mag(cy - mdl_ry);
      sh = 0;
      if (ax >= 64'h80000000 || ay >= 64'h80000000) begin
         ax >>= 1;
         ay >>= 1;
         sh = 1;
      end
      d = floor_sqrt(ax * ax + ay * ay) << sh;
      rm = mag(mdl_rate);
      tm = rm * (d >> 16) + ((rm * (d & 64'hFFFF)) >> 16);
      if (mdl_rate >= 0 && tm >= (64'd11 << 28)) begin
         e = 64'h7FFFFFFF;
         mdl_ovf = 1'b1;
      end else if (mdl_rate < 0 && tm >= (64'd16 << 28)) begin
         e = 0;
      end else begin
         e = exp_fixed(mdl_rate < 0 ? -longint'(tm) : longint'(tm));
         if (e > 64'h7FFFFFFF) begin
            e = 64'h7FFFFFFF;
            mdl_ovf = 1'b1;
         end
      end
      diff = mdl_wmax - mdl_wmin;
      m = mag(diff) * e;
      if (diff < 0) scaled = -longint'((m + 65535) >> 16);
      else scaled = longint'(m >> 16);
      return scaled + mdl_wmin;
   endfunction

   function automatic void predict_request(dxw_pkg::req_type rq);
      longint s;
      dxw_pkg::rsp_type r;
      s = mdl_sum + weight_of(longint'(rq.coord_x), longint'(rq.coord_y));
      if (s > TOTAL_MAX) begin
         s = TOTAL_MAX;
         mdl_ovf = 1'b1;
      end else if (s < TOTAL_MIN) begin
         s = TOTAL_MIN;
         mdl_ovf = 1'b1;
      end
      mdl_sum = s;
      if (rq.last_item) begin
         r.total = s[47:0];
         r.overflowed = mdl_ovf;
         expected_totals.push_back(r);
         mdl_sum = 0;
         mdl_ovf = 1'b0;
      end
   endfunction

   task automatic send_request(logic [31:0] x, logic [31:0] y, bit last);
      dxw_pkg::req_type rq;
      int gap;
      @(negedge clock);
      gap = $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      rq.coord_x = x;
      rq.coord_y = y;
      rq.last_item = last;
      req_data <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(rq);
      requests_sent++;
   endtask

   task automatic write_csr(dxw_pkg::csr_index_type idx, logic [31:0] v);
      csr_index <= idx;
      csr_wdata <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         dxw_pkg::CSR_DECAY_RATE: mdl_rate = longint'(signed'(v));
         dxw_pkg::CSR_WEIGHT_MAX: mdl_wmax = longint'(signed'(v));
         dxw_pkg::CSR_WEIGHT_MIN: mdl_wmin = longint'(signed'(v));
         dxw_pkg::CSR_REF_X: mdl_rx = longint'(signed'(v));
         dxw_pkg::CSR_REF_Y: mdl_ry = longint'(signed'(v));
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_totals.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic set_config(logic [31:0] r, logic [31:0] wmax, logic [31:0] wmin,
                             logic [31:0] x, logic [31:0] y);
      wait_idle();
      write_csr(dxw_pkg::CSR_DECAY_RATE, r);
      write_csr(dxw_pkg::CSR_WEIGHT_MAX, wmax);
      write_csr(dxw_pkg::CSR_WEIGHT_MIN, wmin);
      write_csr(dxw_pkg::CSR_REF_X, x);
      write_csr(dxw_pkg::CSR_REF_Y, y);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         totals_seen++;
         if (expected_totals.size() == 0) begin
            $error("unexpected response total=%0d", rsp_data.total);
            error_count++;
         end else begin
            dxw_pkg::rsp_type ex;
            ex = expected_totals.pop_front();
            if (rsp_data.total !== ex.total) begin
               $error("total expected %0d actual %0d", ex.total, rsp_data.total);
               error_count++;
            end
            if (rsp_data.overflowed !== ex.overflowed) begin
               $error("overflowed expected %0d actual %0d", ex.overflowed,
                      rsp_data.overflowed);
               error_count++;
            end
         end
      end
   end

   initial begin
      int gap;
      forever begin
         @(negedge clock);
         gap = $urandom_range(0, 19);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return $urandom();
         default: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_request(32'h00010000, 32'h00020000, 1'b0);
      send_request(32'h80000000, 32'h7FFFFFFF, 1'b1);
      send_request(32'h0, 32'h0, 1'b1);
   endtask

   task automatic test_directed_edges();
      set_config(32'h10000000, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0);
      send_request(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
      send_request(32'h00010000, 32'h0, 1'b1);
      set_config(32'hF0000000, 32'h00010000, 32'h00008000, 32'h7FFFFFFF, 32'h80000000);
      send_request(32'h80000000, 32'h7FFFFFFF, 1'b0);
      send_request(32'h7FFFFFFF, 32'h80000000, 1'b1);
      send_request(32'h0, 32'h0, 1'b1);
      set_config(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0);
      send_request(32'h0, 32'h0, 1'b0);
      send_request(32'h00001000, 32'h0, 1'b1);
      for (int i = 0; i < 8; i++) send_request(32'h0, 32'h0, i == 7);
      set_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      for (int i = 0; i < 4; i++) send_request(32'h0, 32'h0, i == 3);
      set_config(32'h00000000, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
      for (int i = 0; i < 4; i++) send_request(32'h0, 32'h0, i == 3);
   endtask

   task automatic test_random_lists();
      for (int phase = 0; phase < 20; phase++) begin
         set_config($urandom_range(0, 3) == 0 ? $urandom()
                       : $urandom_range(0, 32'h20000000) - 32'h10000000,
                    $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h00400000),
                    $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h00040000),
                    pick_coord(), pick_coord());
         for (int i = 0; i < 75; i++)
            send_request(pick_coord(), pick_coord(), $urandom_range(0, 5) == 0);
         send_request(pick_coord(), pick_coord(), 1'b1);
      end
   endtask

   initial begin
      mdl_rate = 0;
      mdl_wmax = 65536;
      mdl_wmin = 0;
      mdl_rx = 0;
      mdl_ry = 0;
      mdl_sum = 0;
      mdl_ovf = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_edges();
      test_random_lists();
      wait_idle();
      $display("Covered %0d requests and %0d list totals over several register settings.",
               requests_sent, totals_seen);
      if (error_count == 0 && expected_totals.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
